>>> sv/ctlex_pkg.sv
// Token codes, character constants and classification functions of the C-like lexer.
package ctlex_pkg;

    localparam int unsigned MAX_WORD_LENGTH_DEF = 255;
    localparam int unsigned OUT_DEPTH = 4;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EOF     = 8'hFF;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_AMP  = 3'd1;
    localparam logic [2:0] OP_BAR  = 3'd2;
    localparam logic [2:0] OP_BANG = 3'd3;
    localparam logic [2:0] OP_EQ   = 3'd4;
    localparam logic [2:0] OP_LT   = 3'd5;
    localparam logic [2:0] OP_GT   = 3'd6;

    localparam logic [1:0] FC_LETTER = 2'd0;
    localparam logic [1:0] FC_DIGIT  = 2'd1;
    localparam logic [1:0] FC_OTHER  = 2'd2;

    localparam logic [5:0] TOK_IDENT   = 6'd0;
    localparam logic [5:0] TOK_NUMLIT  = 6'd1;
    localparam logic [5:0] TOK_BADNUM  = 6'd2;
    localparam logic [5:0] TOK_INT     = 6'd3;
    localparam logic [5:0] TOK_UNKNOWN = 6'd7;
    localparam logic [5:0] TOK_SEMI    = 6'd8;
    localparam logic [5:0] TOK_LBRACE  = 6'd9;
    localparam logic [5:0] TOK_RBRACE  = 6'd10;
    localparam logic [5:0] TOK_LPAREN  = 6'd11;
    localparam logic [5:0] TOK_RPAREN  = 6'd12;
    localparam logic [5:0] TOK_SEP     = 6'd13;
    localparam logic [5:0] TOK_ADD     = 6'd14;
    localparam logic [5:0] TOK_MINUS   = 6'd15;
    localparam logic [5:0] TOK_STAR    = 6'd16;
    localparam logic [5:0] TOK_SLASH   = 6'd17;
    localparam logic [5:0] TOK_TILDE   = 6'd18;
    localparam logic [5:0] TOK_PERCENT = 6'd19;
    localparam logic [5:0] TOK_CARET   = 6'd20;
    localparam logic [5:0] TOK_QUEST   = 6'd21;
    localparam logic [5:0] TOK_LABEL   = 6'd22;
    localparam logic [5:0] TOK_AMP     = 6'd23;
    localparam logic [5:0] TOK_ANDAND  = 6'd24;
    localparam logic [5:0] TOK_BAR     = 6'd25;
    localparam logic [5:0] TOK_OROR    = 6'd26;
    localparam logic [5:0] TOK_BANG    = 6'd27;
    localparam logic [5:0] TOK_NE      = 6'd28;
    localparam logic [5:0] TOK_ASSIGN  = 6'd29;
    localparam logic [5:0] TOK_EQEQ    = 6'd30;
    localparam logic [5:0] TOK_GT      = 6'd31;
    localparam logic [5:0] TOK_GE      = 6'd32;
    localparam logic [5:0] TOK_SHR     = 6'd33;
    localparam logic [5:0] TOK_LT      = 6'd34;
    localparam logic [5:0] TOK_LE      = 6'd35;
    localparam logic [5:0] TOK_SHL     = 6'd36;
    localparam logic [5:0] TOK_EOF     = 6'd37;
    localparam logic [5:0] TOK_NONE    = 6'd0;

    localparam logic [7:0] KW_TEXT [0:3][0:5] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n"}
    };
    localparam logic [2:0] KW_LEN [0:3] = '{3'd3, 3'd2, 3'd4, 3'd6};

    typedef struct packed {
        logic [5:0] ttype;
        logic [7:0] tlen;
        logic       tlast;
    } tok_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        if (pos <= 3'd5)
        begin
            r = KW_TEXT[k][pos];
        end
        return r;
    endfunction

    function automatic logic [2:0] prefix_of(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            CH_AMP:  r = OP_AMP;
            CH_BAR:  r = OP_BAR;
            CH_BANG: r = OP_BANG;
            CH_EQ:   r = OP_EQ;
            CH_LT:   r = OP_LT;
            CH_GT:   r = OP_GT;
            default: r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] single_code(input logic [2:0] op);
        logic [5:0] r;
        case (op)
            OP_AMP:  r = TOK_AMP;
            OP_BAR:  r = TOK_BAR;
            OP_BANG: r = TOK_BANG;
            OP_EQ:   r = TOK_ASSIGN;
            OP_LT:   r = TOK_LT;
            default: r = TOK_GT;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] pair_code(input logic [2:0] op, input logic [7:0] c);
        logic [5:0] r;
        r = TOK_NONE;
        case (op)
            OP_AMP:  if (c == CH_AMP) r = TOK_ANDAND;
            OP_BAR:  if (c == CH_BAR) r = TOK_OROR;
            OP_BANG: if (c == CH_EQ) r = TOK_NE;
            OP_EQ:   if (c == CH_EQ) r = TOK_EQEQ;
            OP_LT:
            begin
                if (c == CH_EQ) r = TOK_LE;
                else if (c == CH_LT) r = TOK_SHL;
            end
            OP_GT:
            begin
                if (c == CH_EQ) r = TOK_GE;
                else if (c == CH_GT) r = TOK_SHR;
            end
            default: r = TOK_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] punct_code(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            CH_SEMI:    r = TOK_SEMI;
            CH_LBRACE:  r = TOK_LBRACE;
            CH_RBRACE:  r = TOK_RBRACE;
            CH_LPAREN:  r = TOK_LPAREN;
            CH_RPAREN:  r = TOK_RPAREN;
            CH_COMMA:   r = TOK_SEP;
            CH_PLUS:    r = TOK_ADD;
            CH_MINUS:   r = TOK_MINUS;
            CH_STAR:    r = TOK_STAR;
            CH_SLASH:   r = TOK_SLASH;
            CH_TILDE:   r = TOK_TILDE;
            CH_PERCENT: r = TOK_PERCENT;
            CH_CARET:   r = TOK_CARET;
            CH_QUEST:   r = TOK_QUEST;
            CH_COLON:   r = TOK_LABEL;
            default:    r = TOK_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] word_class(input logic [31:0] len, input logic [1:0] fcc,
                                              input logic malf, input logic [3:0] kwm);
        logic [5:0] r;
        r = TOK_UNKNOWN;
        for (int k = 3; k >= 0; k--)
        begin
            if (kwm[k] && len == 32'(KW_LEN[k]))
            begin
                r = TOK_INT + 6'(k);
            end
        end
        if (r == TOK_UNKNOWN)
        begin
            if (fcc == FC_LETTER)
            begin
                r = TOK_IDENT;
            end
            else if (fcc == FC_DIGIT)
            begin
                r = malf ? TOK_BADNUM : TOK_NUMLIT;
            end
        end
        return r;
    endfunction

endpackage

>>> sv/c_like_token_lexer_core.sv
// Top level of the C-like lexer: per-byte tokenizer with a small result queue.
//
//  channel  | dir | tdata                                     | tlast
//  s_axis   | in  | [7:0] char_code                           | last_char
//  m_axis   | out | [5:0] token_type, [13:6] token_length     | run_last
//
// One byte is taken per cycle; a byte yields zero, one or two tokens in the same cycle.
// Tokens enter a four-entry queue; s_axis_tready is high while two entries are free.
// Tokens leave one per ready cycle; a steady run of two-token bytes halves the byte rate.
// Reset empties the queue and restores an empty word with no pending operator.
// After the end-of-file byte further bytes are taken and dropped until reset.
module c_like_token_lexer_core #(
    parameter int unsigned MAX_WORD_LENGTH = ctlex_pkg::MAX_WORD_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] token_type, [13:6] token_length, [15:14] zero
    output logic        m_axis_tlast
);

    localparam int unsigned WL_W  = $clog2(MAX_WORD_LENGTH + 1);
    localparam int unsigned DEPTH = ctlex_pkg::OUT_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [2:0]      pend_reg, pend_next;
    logic [WL_W-1:0] wlen_reg, wlen_next;
    logic [1:0]      fcc_reg, fcc_next;
    logic            malf_reg, malf_next;
    logic [3:0]      kwm_reg, kwm_next;
    logic            ended_reg, ended_next;

    ctlex_pkg::tok_t  fifo_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    ctlex_pkg::tok_t slot [2];
    logic [1:0]      n_tok;
    logic            accept, pop;

    logic [7:0] c;
    logic [5:0] pc;
    logic [2:0] pfx;
    logic [5:0] pct;
    logic       consumed, is_stop;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = cnt_reg <= CNT_W'(DEPTH - 2);

    always_comb
    begin
        c          = s_axis_tdata;
        pc         = ctlex_pkg::pair_code(pend_reg, c);
        pfx        = ctlex_pkg::prefix_of(c);
        pct        = ctlex_pkg::punct_code(c);
        consumed   = 1'b0;
        is_stop    = 1'b0;
        pend_next  = pend_reg;
        wlen_next  = wlen_reg;
        fcc_next   = fcc_reg;
        malf_next  = malf_reg;
        kwm_next   = kwm_reg;
        ended_next = ended_reg;
        n_tok      = 2'd0;
        slot[0]    = '0;
        slot[1]    = '0;

        if (!ended_reg)
        begin
            if (pend_reg != ctlex_pkg::OP_NONE)
            begin
                if (pc != ctlex_pkg::TOK_NONE)
                begin
                    slot[n_tok[0]].ttype = pc;
                    slot[n_tok[0]].tlen  = 8'd2;
                    consumed = 1'b1;
                end
                else
                begin
                    slot[n_tok[0]].ttype = ctlex_pkg::single_code(pend_reg);
                    slot[n_tok[0]].tlen  = 8'd1;
                end
                n_tok = n_tok + 2'd1;
                pend_next = ctlex_pkg::OP_NONE;
            end

            if (!consumed)
            begin
                is_stop = (c == ctlex_pkg::CH_EOF) || (c == ctlex_pkg::CH_SPACE)
                          || (c == ctlex_pkg::CH_NL) || (pfx != ctlex_pkg::OP_NONE)
                          || (pct != ctlex_pkg::TOK_NONE);
                if (is_stop && wlen_next != '0)
                begin
                    slot[n_tok[0]].ttype = ctlex_pkg::word_class(32'(wlen_next), fcc_next,
                                                                 malf_next, kwm_next);
                    slot[n_tok[0]].tlen  = (32'(wlen_next) > 32'd255) ? 8'd255 : 8'(wlen_next);
                    n_tok     = n_tok + 2'd1;
                    wlen_next = '0;
                    fcc_next  = ctlex_pkg::FC_LETTER;
                    malf_next = 1'b0;
                    kwm_next  = 4'hF;
                end

                if (c == ctlex_pkg::CH_EOF)
                begin
                    slot[n_tok[0]].ttype = ctlex_pkg::TOK_EOF;
                    slot[n_tok[0]].tlen  = 8'd0;
                    n_tok      = n_tok + 2'd1;
                    ended_next = 1'b1;
                end
                else if (pfx != ctlex_pkg::OP_NONE)
                begin
                    pend_next = pfx;
                end
                else if (pct != ctlex_pkg::TOK_NONE)
                begin
                    slot[n_tok[0]].ttype = pct;
                    slot[n_tok[0]].tlen  = 8'd1;
                    n_tok = n_tok + 2'd1;
                end
                else if (!is_stop && c != ctlex_pkg::CH_TAB)
                begin
                    if (wlen_reg == '0)
                    begin
                        fcc_next = ctlex_pkg::is_letter(c) ? ctlex_pkg::FC_LETTER :
                                   (ctlex_pkg::is_digit(c) ? ctlex_pkg::FC_DIGIT :
                                    ctlex_pkg::FC_OTHER);
                    end
                    if (!ctlex_pkg::is_digit(c) && c != ctlex_pkg::CH_DOT)
                    begin
                        malf_next = 1'b1;
                    end
                    for (int k = 0; k < 4; k++)
                    begin
                        if (32'(wlen_reg) >= 32'(ctlex_pkg::KW_LEN[k])
                            || ctlex_pkg::kw_char(2'(k), wlen_reg[2:0]) != c)
                        begin
                            kwm_next[k] = 1'b0;
                        end
                    end
                    if (32'(wlen_reg) < MAX_WORD_LENGTH)
                    begin
                        wlen_next = wlen_reg + 1'b1;
                    end
                end
            end

            if (s_axis_tlast && !ended_next)
            begin
                if (wlen_next != '0)
                begin
                    slot[n_tok[0]].ttype = ctlex_pkg::word_class(32'(wlen_next), fcc_next,
                                                                 malf_next, kwm_next);
                    slot[n_tok[0]].tlen  = (32'(wlen_next) > 32'd255) ? 8'd255 : 8'(wlen_next);
                    n_tok     = n_tok + 2'd1;
                    wlen_next = '0;
                    fcc_next  = ctlex_pkg::FC_LETTER;
                    malf_next = 1'b0;
                    kwm_next  = 4'hF;
                end
                if (pend_next != ctlex_pkg::OP_NONE)
                begin
                    slot[n_tok[0]].ttype = ctlex_pkg::single_code(pend_next);
                    slot[n_tok[0]].tlen  = 8'd1;
                    n_tok     = n_tok + 2'd1;
                    pend_next = ctlex_pkg::OP_NONE;
                end
            end
        end

        if (n_tok == 2'd1)
        begin
            slot[0].tlast = 1'b1;
        end
        else if (n_tok == 2'd2)
        begin
            slot[1].tlast = 1'b1;
        end

        cnt_next = cnt_reg - CNT_W'(pop);
        if (accept)
        begin
            cnt_next = cnt_next + CNT_W'(n_tok);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= ctlex_pkg::OP_NONE;
            wlen_reg  <= '0;
            fcc_reg   <= ctlex_pkg::FC_LETTER;
            malf_reg  <= 1'b0;
            kwm_reg   <= 4'hF;
            ended_reg <= 1'b0;
            wr_reg    <= '0;
            rd_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg  <= pend_next;
                wlen_reg  <= wlen_next;
                fcc_reg   <= fcc_next;
                malf_reg  <= malf_next;
                kwm_reg   <= kwm_next;
                ended_reg <= ended_next;
                wr_reg    <= wr_reg + PTR_W'(n_tok);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && n_tok != 2'd0)
        begin
            fifo_reg[wr_reg] <= slot[0];
        end
        if (accept && n_tok == 2'd2)
        begin
            fifo_reg[wr_reg + 1'b1] <= slot[1];
        end
    end

    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = {2'b00, fifo_reg[rd_reg].tlen, fifo_reg[rd_reg].ttype};
    assign m_axis_tlast  = fifo_reg[rd_reg].tlast;

endmodule

>>> sv/ctlex_checker.sv
// Port-level checks of the C-like lexer and their attachment to the top level.
module ctlex_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready && s_axis_tdata[7] && s_axis_tlast;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("output transfer dropped or changed while stalled");

    a_eof_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[5:0] == ctlex_pkg::TOK_EOF
        |=> !m_axis_tvalid)
        else $error("token after end of file");

    a_eof_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == ctlex_pkg::TOK_EOF
        |-> m_axis_tlast && m_axis_tdata[13:6] == 8'd0)
        else $error("end-of-file token malformed");

    a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] >= ctlex_pkg::TOK_SEMI
        && m_axis_tdata[5:0] <= ctlex_pkg::TOK_SHL
        |-> (m_axis_tdata[13:6] == 8'd1 || m_axis_tdata[13:6] == 8'd2)
            && m_axis_tdata[15:14] == 2'b00)
        else $error("operator token length out of range");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:0] <= ctlex_pkg::TOK_EOF || in_xfer)
        else $error("token code out of range");

endmodule

bind c_like_token_lexer_core ctlex_checker u_ctlex_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the C-like token lexer: byte stream in, predicted tokens checked out.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WLEN_MAX    = ctlex_pkg::MAX_WORD_LENGTH_DEF;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned DRAIN_WAIT  = 20;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_code
    logic        s_axis_tlast  = 1'b0;    // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [5:0] token_type, [13:6] token_length
    logic        m_axis_tlast;            // run_last

    c_like_token_lexer_core #(
        .MAX_WORD_LENGTH(WLEN_MAX)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // lexer state as predicted
    logic [2:0]  pend_op   = ctlex_pkg::OP_NONE;
    int unsigned wlen      = 0;
    logic [1:0]  first_cls = ctlex_pkg::FC_LETTER;
    bit          bad_num   = 1'b0;
    logic [3:0]  kw_live   = 4'hF;
    bit          eof_seen  = 1'b0;
    string       kw_word [4] = '{"int", "if", "else", "return"};

    ctlex_pkg::tok_t step_toks [$];
    ctlex_pkg::tok_t token_q [$];

    bit          steady       = 1'b0;
    int unsigned errors       = 0;
    int unsigned bytes_in     = 0;
    int unsigned tokens_seen  = 0;
    int unsigned stall_cycles = 0;

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [2:0] op_start(input logic [7:0] c);
        case (c)
            ctlex_pkg::CH_AMP:  return ctlex_pkg::OP_AMP;
            ctlex_pkg::CH_BAR:  return ctlex_pkg::OP_BAR;
            ctlex_pkg::CH_BANG: return ctlex_pkg::OP_BANG;
            ctlex_pkg::CH_EQ:   return ctlex_pkg::OP_EQ;
            ctlex_pkg::CH_LT:   return ctlex_pkg::OP_LT;
            ctlex_pkg::CH_GT:   return ctlex_pkg::OP_GT;
            default:            return ctlex_pkg::OP_NONE;
        endcase
    endfunction

    function automatic logic [5:0] op_alone(input logic [2:0] op);
        case (op)
            ctlex_pkg::OP_AMP:  return ctlex_pkg::TOK_AMP;
            ctlex_pkg::OP_BAR:  return ctlex_pkg::TOK_BAR;
            ctlex_pkg::OP_BANG: return ctlex_pkg::TOK_BANG;
            ctlex_pkg::OP_EQ:   return ctlex_pkg::TOK_ASSIGN;
            ctlex_pkg::OP_LT:   return ctlex_pkg::TOK_LT;
            default:            return ctlex_pkg::TOK_GT;
        endcase
    endfunction

    function automatic logic [5:0] op_pair(input logic [2:0] op, input logic [7:0] c);
        if (op == ctlex_pkg::OP_AMP && c == ctlex_pkg::CH_AMP) return ctlex_pkg::TOK_ANDAND;
        if (op == ctlex_pkg::OP_BAR && c == ctlex_pkg::CH_BAR) return ctlex_pkg::TOK_OROR;
        if (op == ctlex_pkg::OP_BANG && c == ctlex_pkg::CH_EQ) return ctlex_pkg::TOK_NE;
        if (op == ctlex_pkg::OP_EQ && c == ctlex_pkg::CH_EQ) return ctlex_pkg::TOK_EQEQ;
        if (op == ctlex_pkg::OP_LT && c == ctlex_pkg::CH_EQ) return ctlex_pkg::TOK_LE;
        if (op == ctlex_pkg::OP_LT && c == ctlex_pkg::CH_LT) return ctlex_pkg::TOK_SHL;
        if (op == ctlex_pkg::OP_GT && c == ctlex_pkg::CH_EQ) return ctlex_pkg::TOK_GE;
        if (op == ctlex_pkg::OP_GT && c == ctlex_pkg::CH_GT) return ctlex_pkg::TOK_SHR;
        return ctlex_pkg::TOK_NONE;
    endfunction

    function automatic logic [5:0] punct_tok(input logic [7:0] c);
        case (c)
            ctlex_pkg::CH_SEMI:    return ctlex_pkg::TOK_SEMI;
            ctlex_pkg::CH_LBRACE:  return ctlex_pkg::TOK_LBRACE;
            ctlex_pkg::CH_RBRACE:  return ctlex_pkg::TOK_RBRACE;
            ctlex_pkg::CH_LPAREN:  return ctlex_pkg::TOK_LPAREN;
            ctlex_pkg::CH_RPAREN:  return ctlex_pkg::TOK_RPAREN;
            ctlex_pkg::CH_COMMA:   return ctlex_pkg::TOK_SEP;
            ctlex_pkg::CH_PLUS:    return ctlex_pkg::TOK_ADD;
            ctlex_pkg::CH_MINUS:   return ctlex_pkg::TOK_MINUS;
            ctlex_pkg::CH_STAR:    return ctlex_pkg::TOK_STAR;
            ctlex_pkg::CH_SLASH:   return ctlex_pkg::TOK_SLASH;
            ctlex_pkg::CH_TILDE:   return ctlex_pkg::TOK_TILDE;
            ctlex_pkg::CH_PERCENT: return ctlex_pkg::TOK_PERCENT;
            ctlex_pkg::CH_CARET:   return ctlex_pkg::TOK_CARET;
            ctlex_pkg::CH_QUEST:   return ctlex_pkg::TOK_QUEST;
            ctlex_pkg::CH_COLON:   return ctlex_pkg::TOK_LABEL;
            default:               return ctlex_pkg::TOK_NONE;
        endcase
    endfunction

    function automatic void add_token(input logic [5:0] kind, input int unsigned len);
        ctlex_pkg::tok_t t;
        t.ttype = kind;
        t.tlen  = (len > 255) ? 8'd255 : 8'(len);
        t.tlast = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic logic [5:0] word_kind();
        logic [5:0] kind = ctlex_pkg::TOK_UNKNOWN;
        for (int k = 0; k < 4; k++)
        begin
            if (kind == ctlex_pkg::TOK_UNKNOWN && kw_live[k] && wlen == kw_word[k].len())
            begin
                kind = ctlex_pkg::TOK_INT + 6'(k);
            end
        end
        if (kind == ctlex_pkg::TOK_UNKNOWN)
        begin
            if (first_cls == ctlex_pkg::FC_LETTER)
            begin
                kind = ctlex_pkg::TOK_IDENT;
            end
            else if (first_cls == ctlex_pkg::FC_DIGIT)
            begin
                kind = bad_num ? ctlex_pkg::TOK_BADNUM : ctlex_pkg::TOK_NUMLIT;
            end
        end
        return kind;
    endfunction

    function automatic void flush_word();
        if (wlen != 0)
        begin
            add_token(word_kind(), wlen);
            wlen      = 0;
            first_cls = ctlex_pkg::FC_LETTER;
            bad_num   = 1'b0;
            kw_live   = 4'hF;
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int unsigned pos = wlen;
        if (pos == 0)
        begin
            first_cls = is_alpha(c) ? ctlex_pkg::FC_LETTER
                                    : (is_num(c) ? ctlex_pkg::FC_DIGIT : ctlex_pkg::FC_OTHER);
        end
        if (!is_num(c) && c != ctlex_pkg::CH_DOT)
        begin
            bad_num = 1'b1;
        end
        for (int k = 0; k < 4; k++)
        begin
            if (pos >= kw_word[k].len() || kw_word[k][pos] != c)
            begin
                kw_live[k] = 1'b0;
            end
        end
        if (wlen < WLEN_MAX)
        begin
            wlen++;
        end
    endfunction

    function automatic void lex_predict(input logic [7:0] c, input logic lst);
        bit         used = 1'b0;
        logic [5:0] duo;
        if (eof_seen)
        begin
            return;
        end
        step_toks.delete();
        if (pend_op != ctlex_pkg::OP_NONE)
        begin
            duo = op_pair(pend_op, c);
            if (duo != ctlex_pkg::TOK_NONE)
            begin
                add_token(duo, 2);
                used = 1'b1;
            end
            else
            begin
                add_token(op_alone(pend_op), 1);
            end
            pend_op = ctlex_pkg::OP_NONE;
        end
        if (!used)
        begin
            if (c == ctlex_pkg::CH_EOF)
            begin
                flush_word();
                add_token(ctlex_pkg::TOK_EOF, 0);
                eof_seen = 1'b1;
            end
            else if (c == ctlex_pkg::CH_SPACE || c == ctlex_pkg::CH_NL)
            begin
                flush_word();
            end
            else if (op_start(c) != ctlex_pkg::OP_NONE)
            begin
                flush_word();
                pend_op = op_start(c);
            end
            else if (punct_tok(c) != ctlex_pkg::TOK_NONE)
            begin
                flush_word();
                add_token(punct_tok(c), 1);
            end
            else if (c != ctlex_pkg::CH_TAB)
            begin
                take_char(c);
            end
        end
        if (lst && !eof_seen)
        begin
            flush_word();
            if (pend_op != ctlex_pkg::OP_NONE)
            begin
                add_token(op_alone(pend_op), 1);
                pend_op = ctlex_pkg::OP_NONE;
            end
        end
        if (step_toks.size() > 0)
        begin
            step_toks[step_toks.size() - 1].tlast = 1'b1;
        end
        foreach (step_toks[i])
        begin
            token_q.push_back(step_toks[i]);
        end
    endfunction

    // sample both streams at the edge; predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        ctlex_pkg::tok_t got;
        ctlex_pkg::tok_t want;
        bit   moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                lex_predict(s_axis_tdata, s_axis_tlast);
                bytes_in++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ttype = m_axis_tdata[5:0];
                got.tlen  = m_axis_tdata[13:6];
                got.tlast = m_axis_tlast;
                if (token_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected token type %0d len %0d last %0d",
                                         got.ttype, got.tlen, got.tlast));
                end
                else
                begin
                    want = token_q.pop_front();
                    if (got.ttype !== want.ttype || got.tlen !== want.tlen ||
                        got.tlast !== want.tlast)
                    begin
                        flag_error($sformatf({"token %0d: expected type %0d len %0d last %0d,",
                                              " got type %0d len %0d last %0d"},
                                             tokens_seen, want.ttype, want.tlen, want.tlast,
                                             got.ttype, got.tlen, got.tlast));
                    end
                end
                tokens_seen++;
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] c, input bit lst);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= lst;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                    : 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] rand_gap();
        string gaps = " \n\t";
        return gaps[$urandom_range(0, 2)];
    endfunction

    task automatic test_directed();
        send_text("int ", 1'b0);
        send_text("i\tf;", 1'b0);
        send_text("else\n", 1'b0);
        send_text("return==", 1'b0);
        send_text("9z<\t3.", 1'b1);
        send_text("#!", 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFE, 1'b0);
        send_text("<a", 1'b1);
    endtask

    task automatic test_long_words();
        string tail = "0123456789.";
        send_text("return", 1'b0);
        repeat (254)
        begin
            send_byte($urandom_range(0, 1) ? rand_letter() : 8'($urandom_range("0", "9")), 1'b0);
        end
        send_byte(ctlex_pkg::CH_SPACE, 1'b0);
        repeat (257)
        begin
            send_byte(tail[$urandom_range(0, 10)], 1'b0);
        end
        send_byte("7", 1'b1);
    endtask

    task automatic test_random_text(input int unsigned n_bytes);
        logic [7:0]  frag [$];
        int unsigned sent = 0;
        int unsigned pick;
        string       kw;
        string       punct  = ";{}(),+-*/~%^?:";
        string       prefix = "&|!=<>";
        string       second = "=&|<>";
        string       numch  = "0123456789.";
        while (sent < n_bytes)
        begin
            steady = (sent >= n_bytes / 3) && (sent < n_bytes / 2);
            frag.delete();
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                kw = kw_word[$urandom_range(0, 3)];
                for (int i = 0; i < kw.len(); i++)
                begin
                    frag.push_back(kw[i]);
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    frag[$urandom_range(0, frag.size() - 1)] = rand_letter();
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    frag.push_back(rand_letter());
                end
            end
            else if (pick < 35)
            begin
                frag.push_back(rand_letter());
                repeat ($urandom_range(0, 7))
                begin
                    case ($urandom_range(0, 3))
                        0:       frag.push_back(8'($urandom_range("0", "9")));
                        1:       frag.push_back("_");
                        default: frag.push_back(rand_letter());
                    endcase
                end
            end
            else if (pick < 50)
            begin
                frag.push_back(8'($urandom_range("0", "9")));
                repeat ($urandom_range(0, 5))
                begin
                    frag.push_back(numch[$urandom_range(0, 10)]);
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    frag.push_back(rand_letter());
                end
            end
            else if (pick < 65)
            begin
                frag.push_back(prefix[$urandom_range(0, 5)]);
                if ($urandom_range(0, 1))
                begin
                    frag.push_back(second[$urandom_range(0, 4)]);
                end
            end
            else if (pick < 80)
            begin
                frag.push_back(punct[$urandom_range(0, 14)]);
            end
            else if (pick < 90)
            begin
                frag.push_back(rand_gap());
            end
            else
            begin
                frag.push_back(8'($urandom_range(0, 254)));
            end
            if ($urandom_range(0, 1))
            begin
                frag.push_back($urandom_range(0, 1) ? ctlex_pkg::CH_SPACE : ctlex_pkg::CH_NL);
            end
            foreach (frag[i])
            begin
                send_byte(frag[i], $urandom_range(0, 99) < 3);
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_end_of_file();
        send_text("ab>", 1'b0);
        send_byte(ctlex_pkg::CH_EOF, 1'b1);
        send_text("x;", 1'b0);
        send_byte(ctlex_pkg::CH_EOF, 1'b0);
        send_byte("=", 1'b1);
    endtask

    initial
    begin
        repeat (7)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_words();
        test_random_text(1330);
        test_end_of_file();
        s_axis_tvalid <= 1'b0;

        while (token_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT)
        begin
            @(posedge clk);
        end
        if (token_q.size() != 0)
        begin
            flag_error($sformatf("%0d expected tokens never arrived", token_q.size()));
        end

        $display("Fed %0d source bytes: keywords, words, numbers, operators, tabs, long words,",
                 bytes_in);
        $display("line ends and end of file; compared %0d tokens, %0d mismatches",
                 tokens_seen, errors);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/ctlex_pkg.sv
sv/c_like_token_lexer_core.sv
sv/ctlex_checker.sv
tb/sv/testbench.sv
